// ===== rtl/dsr_pkg.sv =====
// Shared types and codes for the double-ended queue engine.
package dsr_pkg;

  typedef enum logic [3:0] {
    KIND_PUSH_FRONT = 4'd0,
    KIND_PUSH_BACK  = 4'd1,
    KIND_POP_FRONT  = 4'd2,
    KIND_POP_BACK   = 4'd3,
    KIND_SORT       = 4'd4,
    KIND_REVERSE    = 4'd5,
    KIND_LIST       = 4'd6,
    KIND_SIZE       = 4'd7,
    KIND_FRONT      = 4'd8,
    KIND_BACK       = 4'd9
  } kind_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_PUSH_FRONT,
    DP_PUSH_BACK,
    DP_POP_FRONT,
    DP_POP_BACK,
    DP_REVERSE,
    DP_SHIFT_LEFT,
    DP_ROTATE,
    DP_SORT_EVEN,
    DP_SORT_ODD
  } dp_op_e;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_MINUS_ONE,
    SRC_FRONT,
    SRC_BACK,
    SRC_COUNT
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REV_SHIFT,
    ST_SORT,
    ST_LIST
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   clear;
    logic   emit;
    src_e   src;
    logic   has;
    logic   last;
    logic   refused;
  } dp_cmd_t;

endpackage

// ===== rtl/dsr_datapath.sv =====
// Element cells, fill count and result registers of the queue engine.
module dsr_datapath import dsr_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_cmd_t       cmd_i,
  input  logic [31:0]   operand_i,
  output logic [CW-1:0] count_o,
  output logic          valid_o,
  output logic [31:0]   item_value_o,
  output logic          has_value_o,
  output logic          line_last_o,
  output logic          push_refused_o
);

  logic signed [VALUE_BITS-1:0] cell_q [DEPTH];
  logic signed [VALUE_BITS-1:0] cell_d [DEPTH];
  logic signed [VALUE_BITS-1:0] op_val;
  logic signed [VALUE_BITS-1:0] back_val;
  logic signed [VALUE_BITS-1:0] sel_val;
  logic [CW-1:0] count_q, count_d, n_eff;
  logic [31:0]   val32;
  logic          valid_q, has_q, last_q, ref_q;
  logic [31:0]   value_q;

  generate
    if (VALUE_BITS <= 32) begin : g_narrow_in
      assign op_val = operand_i[VALUE_BITS-1:0];
    end else begin : g_wide_in
      assign op_val = {{(VALUE_BITS-32){operand_i[31]}}, operand_i};
    end
    if (VALUE_BITS >= 32) begin : g_wide_out
      assign val32 = sel_val[31:0];
    end else begin : g_narrow_out
      assign val32 = {{(32-VALUE_BITS){sel_val[VALUE_BITS-1]}}, sel_val};
    end
  endgenerate

  assign n_eff   = cmd_i.clear ? '0 : count_q;
  assign count_o = n_eff;

  always_comb begin
    back_val = cell_q[0];
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i + 1) == n_eff) back_val = cell_q[i];
    end
  end

  always_comb begin
    cell_d  = cell_q;
    count_d = n_eff;
    unique case (cmd_i.op)
      DP_PUSH_FRONT: begin
        for (int i = 1; i < DEPTH; i++) cell_d[i] = cell_q[i-1];
        cell_d[0] = op_val;
        count_d   = n_eff + 1'b1;
      end
      DP_PUSH_BACK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == n_eff) cell_d[i] = op_val;
        end
        count_d = n_eff + 1'b1;
      end
      DP_POP_FRONT: begin
        for (int i = 0; i < DEPTH - 1; i++) cell_d[i] = cell_q[i+1];
        count_d = n_eff - 1'b1;
      end
      DP_POP_BACK:   count_d = n_eff - 1'b1;
      DP_REVERSE: begin
        for (int i = 0; i < DEPTH; i++) cell_d[i] = cell_q[DEPTH-1-i];
      end
      DP_SHIFT_LEFT: begin
        for (int i = 0; i < DEPTH - 1; i++) cell_d[i] = cell_q[i+1];
      end
      DP_ROTATE: begin
        for (int i = 0; i < DEPTH - 1; i++) cell_d[i] = cell_q[i+1];
        cell_d[DEPTH-1] = cell_q[0];
      end
      DP_SORT_EVEN, DP_SORT_ODD: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if ((i % 2 == 0) == (cmd_i.op == DP_SORT_EVEN) && CW'(i + 1) < n_eff
              && cell_q[i+1] < cell_q[i]) begin
            cell_d[i]   = cell_q[i+1];
            cell_d[i+1] = cell_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd_i.src)
      SRC_MINUS_ONE: sel_val = '1;
      SRC_FRONT:     sel_val = cell_q[0];
      SRC_BACK:      sel_val = back_val;
      default:       sel_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      value_q <= (cmd_i.src == SRC_COUNT) ? 32'(n_eff) : val32;
      has_q   <= cmd_i.has;
      last_q  <= cmd_i.last;
      ref_q   <= cmd_i.refused;
    end
  end

  assign valid_o        = valid_q;
  assign item_value_o   = value_q;
  assign has_value_o    = has_q;
  assign line_last_o    = last_q;
  assign push_refused_o = ref_q;

endmodule

// ===== rtl/dsr_controller.sv =====
// Command sequencer of the queue engine: decodes items and walks the cells.
module dsr_controller import dsr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [3:0]    kind_i,
  input  logic          start_case_i,
  input  logic [CW-1:0] count_i,
  output logic          busy,
  output dp_cmd_t       cmd_o
);

  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] LastK  = CW'(DEPTH - 1);

  state_e        state_q, state_d;
  logic [CW-1:0] k_q, k_d;
  logic          ref_q, ref_d;
  logic          accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      ref_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ref_q   <= ref_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ref_d   = ref_q;
    cmd_o   = '{op: DP_NONE, clear: 1'b0, emit: 1'b0, src: SRC_ZERO,
                has: 1'b1, last: 1'b1, refused: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.clear = start_case_i;
          ref_d       = 1'b0;
          k_d         = '0;
          state_d     = ST_LIST;
          unique case (kind_i)
            KIND_PUSH_FRONT: begin
              if (count_i == DepthC) ref_d = 1'b1;
              else cmd_o.op = DP_PUSH_FRONT;
            end
            KIND_PUSH_BACK: begin
              if (count_i == DepthC) ref_d = 1'b1;
              else cmd_o.op = DP_PUSH_BACK;
            end
            KIND_POP_FRONT: if (count_i != '0) cmd_o.op = DP_POP_FRONT;
            KIND_POP_BACK: begin
              if (count_i != '0) cmd_o.op = DP_POP_BACK;
              if (count_i <= CW'(1)) begin
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_MINUS_ONE;
                state_d    = ST_IDLE;
              end
            end
            KIND_SORT: state_d = ST_SORT;
            KIND_REVERSE: begin
              cmd_o.op = DP_REVERSE;
              if (count_i != DepthC) begin
                k_d     = count_i;
                state_d = ST_REV_SHIFT;
              end
            end
            KIND_LIST: ;
            KIND_SIZE: begin
              cmd_o.emit = 1'b1;
              cmd_o.src  = SRC_COUNT;
              state_d    = ST_IDLE;
            end
            KIND_FRONT, KIND_BACK: begin
              cmd_o.emit = 1'b1;
              if (count_i == '0) cmd_o.src = SRC_MINUS_ONE;
              else if (kind_i == KIND_FRONT) cmd_o.src = SRC_FRONT;
              else cmd_o.src = SRC_BACK;
              state_d = ST_IDLE;
            end
            default: begin
              cmd_o.emit = 1'b1;
              cmd_o.has  = 1'b0;
              state_d    = ST_IDLE;
            end
          endcase
        end
      end
      ST_REV_SHIFT: begin
        cmd_o.op = DP_SHIFT_LEFT;
        k_d      = k_q + 1'b1;
        if (k_q == LastK) begin
          k_d     = '0;
          state_d = ST_LIST;
        end
      end
      ST_SORT: begin
        cmd_o.op = k_q[0] ? DP_SORT_ODD : DP_SORT_EVEN;
        k_d      = k_q + 1'b1;
        if (k_q == LastK) begin
          k_d     = '0;
          state_d = ST_LIST;
        end
      end
      ST_LIST: begin
        cmd_o.refused = ref_q;
        if (count_i == '0) begin
          cmd_o.emit = 1'b1;
          cmd_o.has  = 1'b0;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.op   = DP_ROTATE;
          cmd_o.emit = (k_q < count_i);
          cmd_o.src  = SRC_FRONT;
          cmd_o.last = (k_q + 1'b1 == count_i);
          k_d        = k_q + 1'b1;
          if (k_q == LastK) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/deque_sort_reverse_engine.sv =====
// Top level of the bounded double-ended queue engine with sort and reverse.
// Size, front, back, pop back to empty and unknown kinds show their single item in the cycle
// after acceptance, and the next item can be accepted on the following cycle.
// A listing line enters the list state, then shows one item per cycle, keeping busy high
// while it steps through every cell position (just the empty item if empty); sort first adds
// DEPTH passes and reverse DEPTH minus the fill count shifts. Results never stall.
// Reset clears the fill count and the controller; element cells hold no reset value.
module deque_sort_reverse_engine import dsr_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind_i,
  input  logic [31:0] operand_i,
  input  logic        start_case_i,
  output logic        valid_o,
  output logic [31:0] item_value_o,
  output logic        has_value_o,
  output logic        line_last_o,
  output logic        push_refused_o
);

  localparam int CW = $clog2(DEPTH + 1);

  // The controller issues one datapath command per cycle and sees only the fill count.
  dp_cmd_t       cmd;
  logic [CW-1:0] count;

  dsr_controller #(.DEPTH(DEPTH), .CW(CW)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .kind_i       (kind_i),
    .start_case_i (start_case_i),
    .count_i      (count),
    .busy         (busy),
    .cmd_o        (cmd)
  );

  dsr_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .CW(CW)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operand_i      (operand_i),
    .count_o        (count),
    .valid_o        (valid_o),
    .item_value_o   (item_value_o),
    .has_value_o    (has_value_o),
    .line_last_o    (line_last_o),
    .push_refused_o (push_refused_o)
  );

  // The fill count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(DEPTH)) else $error("fill count above capacity");

  // An empty line is always a complete line.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !has_value_o |-> line_last_o) else $error("empty item not last");

  // A refused push lists a full queue, so every item of its line carries a value.
  a_refused_has: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && push_refused_o |-> has_value_o) else $error("refused item without value");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue engine with sort and reverse.
module testbench;
  import dsr_pkg::*;

  localparam int DEPTH = 16;

  // One result of a command line, as seen on the result ports.
  typedef struct packed {
    logic [31:0] value;
    logic        has;
    logic        last;
    logic        refused;
  } line_item_t;

  // The scoreboard keeps its own copy of the queue, works out the line that every
  // accepted command should produce, and compares results in order.
  class deque_scoreboard;
    logic signed [31:0] cells[DEPTH];
    int unsigned        fill;
    line_item_t         pending[$];
    int                 mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void add_line(logic refused);
      line_item_t li;
      if (fill == 0) begin
        li = '{32'd0, 1'b0, 1'b1, refused};
        pending = {pending, li};
      end else begin
        for (int i = 0; i < fill; i++) begin
          li = '{cells[i], 1'b1, (i == fill - 1), refused};
          pending = {pending, li};
        end
      end
    endfunction

    function void add_single(logic [31:0] v, logic has);
      line_item_t li;
      li = '{v, has, 1'b1, 1'b0};
      pending = {pending, li};
    endfunction

    // Notes an accepted command: updates the queue copy and queues the expected line.
    function void note_command(logic [3:0] kind, logic [31:0] operand, logic start_case);
      logic signed [31:0] key;
      int j;
      if (start_case) fill = 0;
      case (kind)
        KIND_PUSH_FRONT: begin
          if (fill >= DEPTH) add_line(1'b1);
          else begin
            for (int i = fill; i > 0; i--) cells[i] = cells[i-1];
            cells[0] = operand;
            fill++;
            add_line(1'b0);
          end
        end
        KIND_PUSH_BACK: begin
          if (fill >= DEPTH) add_line(1'b1);
          else begin
            cells[fill] = operand;
            fill++;
            add_line(1'b0);
          end
        end
        KIND_POP_FRONT: begin
          if (fill > 0) begin
            for (int i = 0; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
          add_line(1'b0);
        end
        KIND_POP_BACK: begin
          if (fill > 0) fill--;
          // Popping the back down to empty reports -1 instead of an empty line.
          if (fill == 0) add_single(32'hFFFF_FFFF, 1'b1);
          else add_line(1'b0);
        end
        KIND_SORT: begin
          for (int i = 1; i < fill; i++) begin
            key = cells[i];
            j = i;
            while (j > 0 && key < cells[j-1]) begin
              cells[j] = cells[j-1];
              j--;
            end
            cells[j] = key;
          end
          add_line(1'b0);
        end
        KIND_REVERSE: begin
          for (int i = 0; i < fill / 2; i++) begin
            key = cells[i];
            cells[i] = cells[fill-1-i];
            cells[fill-1-i] = key;
          end
          add_line(1'b0);
        end
        KIND_LIST: add_line(1'b0);
        KIND_SIZE: add_single(32'(fill), 1'b1);
        KIND_FRONT: add_single(fill ? cells[0] : 32'hFFFF_FFFF, 1'b1);
        KIND_BACK: add_single(fill ? cells[fill-1] : 32'hFFFF_FFFF, 1'b1);
        default: add_single(32'd0, 1'b0);
      endcase
    endfunction

    // Checks one result against the oldest expectation.
    function void check_result(line_item_t got);
      line_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: value=%h has=%b last=%b refused=%b",
                   got.value, got.has, got.last, got.refused);
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%h has=%b last=%b refused=%b, got %h %b %b %b",
                   want.value, want.has, want.last, want.refused,
                   got.value, got.has, got.last, got.refused);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  kind_i = '0;
  logic [31:0] operand_i = '0;
  logic        start_case_i = 1'b0;
  logic        valid_o;
  logic [31:0] item_value_o;
  logic        has_value_o;
  logic        line_last_o;
  logic        push_refused_o;

  deque_scoreboard sb;
  int idle_pct;

  always #5 clk_i = ~clk_i;

  deque_sort_reverse_engine #(.DEPTH(DEPTH), .VALUE_BITS(32)) dut (.*);

  // Results last a single cycle, so every strobe is taken at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_result('{item_value_o, has_value_o, line_last_o, push_refused_o});
  end

  // Presents one command and holds it until the block takes it. Start stays high
  // into the next command when no idle gap follows, so it is never lowered and
  // raised in the same step.
  task automatic send_command(input logic [3:0] kind, input logic [31:0] operand,
                              input logic start_case);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= kind;
    operand_i    <= operand;
    start_case_i <= start_case;
    do @(posedge clk_i); while (busy);
    sb.note_command(kind, operand, start_case);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected item has come, then lets the block settle.
  task automatic drain();
    release_start();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3 * DEPTH) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Random kind weighted toward pushes so the queue often fills up; now and then
  // an unknown kind.
  function automatic logic [3:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 22) return KIND_PUSH_FRONT;
    if (r < 44) return KIND_PUSH_BACK;
    if (r < 96) return 4'($urandom_range(KIND_BACK, KIND_POP_FRONT));
    return 4'($urandom_range(15, 10));
  endfunction

  initial begin
    sb = new();
    idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-queue cases, extremes, fill to capacity, every kind.
    send_command(KIND_LIST, 0, 1'b0);
    send_command(KIND_POP_FRONT, 0, 1'b0);
    send_command(KIND_POP_BACK, 0, 1'b0);
    send_command(KIND_FRONT, 0, 1'b0);
    send_command(KIND_BACK, 0, 1'b0);
    send_command(KIND_SIZE, 0, 1'b0);
    send_command(4'd15, 32'hFFFF_FFFF, 1'b0);
    send_command(KIND_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
    send_command(KIND_PUSH_FRONT, 32'h8000_0000, 1'b0);
    send_command(KIND_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
    send_command(KIND_SORT, 0, 1'b0);
    send_command(KIND_REVERSE, 0, 1'b0);
    for (int i = 0; i < 14; i++)
      send_command(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom, 1'b0);
    send_command(KIND_SORT, 0, 1'b0);
    send_command(KIND_FRONT, 0, 1'b0);
    send_command(KIND_BACK, 0, 1'b0);
    send_command(KIND_POP_BACK, 0, 1'b0);
    send_command(KIND_LIST, 0, 1'b1);
    send_command(KIND_PUSH_BACK, 5, 1'b0);
    send_command(KIND_POP_BACK, 0, 1'b0);
    // The sender waits here for the whole backlog to drain.
    drain();

    // Random part in three idle regimes.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 67 : 0;
      for (int n = 0; n < 150; n++)
        send_command(pick_kind(), pick_operand(), $urandom_range(39) == 0);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dsr_pkg.sv
rtl/dsr_datapath.sv
rtl/dsr_controller.sv
rtl/deque_sort_reverse_engine.sv
tb/testbench.sv
